// ===== src/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the minimum-tracking stack: depth, count
// widths, status codes and the command/status groups between the blocks.
// ----------------------------------------------------------------------------
package mts_pkg;

	localparam int MTS_DEPTH = 64;
	localparam int MTS_AW    = $clog2(MTS_DEPTH);
	localparam int MTS_CW    = $clog2(MTS_DEPTH + 1);
	localparam int MTS_DW    = 32;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_PUSH_FULL = 2'd2
	} mts_status_t;

	// controller to datapath
	typedef struct packed {
		logic push_exec;
		logic pop_exec;
		logic load_tops;
		logic load_out;
	} mts_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic              empty;
		logic [MTS_CW-1:0] data_count;
		logic [MTS_CW-1:0] min_count;
	} mts_stat_t;

	// registered result item
	typedef struct packed {
		logic signed [MTS_DW-1:0] top_value;
		logic signed [MTS_DW-1:0] min_value;
		logic                     is_empty;
		mts_status_t              status;
	} mts_result_t;

endpackage

// ===== src/mts_if.sv =====
// ----------------------------------------------------------------------------
// mts_in_if / mts_out_if
// Valid/ready channels for the stack operation items and the result items.
// ----------------------------------------------------------------------------
interface mts_in_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic signed [31:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink (input valid, input func, input value, output ready);
endinterface

interface mts_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] top_value;
	logic signed [31:0] min_value;
	logic               is_empty;
	logic [1:0]         status;

	modport source (output valid, output top_value, output min_value, output is_empty,
		output status, input ready);
	modport sink (input valid, input top_value, input min_value, input is_empty,
		input status, output ready);
endinterface

// ===== src/min_tracking_stack_top.sv =====
// ----------------------------------------------------------------------------
// min_tracking_stack_top
// LIFO stack of signed 32-bit values that reports its minimum after every
// push or pop, using an auxiliary stack of running minimums.
//
//   channel  dir  payload                                  handshake
//   req      in   func, value                              valid / ready
//   rsp      out  top_value, min_value, is_empty, status   valid / ready
//
// a push or a pop on an empty stack goes from S_IDLE straight to S_RESULT, any
// other pop also passes through S_LOAD (for the memory read of the entry below
// the top); the tops live in registers, the rest in the stack memories
// a new item is taken while the previous result waits in the output register
// a stalled output holds the finished result of the next item in the datapath
// reset clears the counts and the sequencer; no memory clearing pass is needed
// ----------------------------------------------------------------------------
module min_tracking_stack_top import mts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	mts_in_if.sink    req,
	mts_out_if.source rsp
);

	mts_cmd_t    cmd;
	mts_stat_t   stat;
	mts_result_t result;

	// sequencer
	mts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.func),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// stacks and result register
	mts_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.value  (req.value),
		.stat   (stat),
		.result (result)
	);

	assign rsp.top_value = result.top_value;
	assign rsp.min_value = result.min_value;
	assign rsp.is_empty  = result.is_empty;
	assign rsp.status    = result.status;

	// minimum stack never deeper than the data stack
	a_min_le_data: assert property (@(posedge clk) disable iff (!arst_n)
		stat.min_count <= stat.data_count)
		else $error("min stack deeper than data stack");

	// data count stays within the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.data_count <= MTS_CW'(MTS_DEPTH))
		else $error("data count beyond stack depth");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("item taken while previous one in flight");

	// empty result shows zero top and minimum
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.is_empty) |-> (rsp.top_value == '0 && rsp.min_value == '0))
		else $error("empty result with nonzero top or minimum");

endmodule

// ===== src/mts_datapath.sv =====
// ----------------------------------------------------------------------------
// mts_datapath
// Data and minimum stacks: cached top registers, counts, the two stack
// memories with registered read, and the result register.
// ----------------------------------------------------------------------------
module mts_datapath import mts_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mts_cmd_t                 cmd,
	input  logic signed [MTS_DW-1:0] value,
	output mts_stat_t                stat,
	output mts_result_t              result
);

	logic [MTS_DW-1:0]        data_mem [MTS_DEPTH];
	logic [MTS_DW-1:0]        min_mem  [MTS_DEPTH];
	logic [MTS_DW-1:0]        data_rd_q;
	logic [MTS_DW-1:0]        min_rd_q;
	logic signed [MTS_DW-1:0] data_top_q;
	logic signed [MTS_DW-1:0] min_top_q;
	logic [MTS_CW-1:0]        data_count_q;
	logic [MTS_CW-1:0]        min_count_q;
	logic                     min_popped_q;
	mts_status_t              status_q;
	mts_result_t              result_q;

	logic              full;
	logic              empty;
	logic              min_push;
	logic              min_pop;
	logic [MTS_CW-1:0] data_below;
	logic [MTS_CW-1:0] min_below;

	// push and pop decisions on the current tops
	assign full       = (data_count_q == MTS_CW'(MTS_DEPTH));
	assign empty      = (data_count_q == '0);
	assign min_push   = !full && ((min_count_q == '0) || (value <= min_top_q));
	assign min_pop    = !empty && (min_count_q != '0) && (min_top_q == data_top_q);
	assign data_below = data_count_q - MTS_CW'(2);
	assign min_below  = min_count_q - MTS_CW'(2);

	// stack memories, entry below the top read on a pop
	always_ff @(posedge clk) begin
		if (cmd.push_exec && !full) begin
			data_mem[data_count_q[MTS_AW-1:0]] <= value;
			if (min_push) begin
				min_mem[min_count_q[MTS_AW-1:0]] <= value;
			end
		end
		data_rd_q <= data_mem[data_below[MTS_AW-1:0]];
		min_rd_q  <= min_mem[min_below[MTS_AW-1:0]];
	end

	// counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_count_q <= '0;
			min_count_q  <= '0;
		end else if (cmd.push_exec && !full) begin
			data_count_q <= data_count_q + MTS_CW'(1);
			if (min_push) begin
				min_count_q <= min_count_q + MTS_CW'(1);
			end
		end else if (cmd.pop_exec && !empty) begin
			data_count_q <= data_count_q - MTS_CW'(1);
			if (min_pop) begin
				min_count_q <= min_count_q - MTS_CW'(1);
			end
		end
	end

	// cached tops and item status
	always_ff @(posedge clk) begin
		if (cmd.push_exec) begin
			status_q <= full ? ST_PUSH_FULL : ST_OK;
			if (!full) begin
				data_top_q <= value;
				if (min_push) begin
					min_top_q <= value;
				end
			end
		end else if (cmd.pop_exec) begin
			status_q     <= empty ? ST_POP_EMPTY : ST_OK;
			min_popped_q <= min_pop;
		end else if (cmd.load_tops) begin
			data_top_q <= data_rd_q;
			if (min_popped_q) begin
				min_top_q <= min_rd_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_q.is_empty  <= empty;
			result_q.status    <= status_q;
			result_q.top_value <= empty ? '0 : data_top_q;
			result_q.min_value <= (empty || min_count_q == '0) ? '0 : min_top_q;
		end
	end

	assign stat.empty      = empty;
	assign stat.data_count = data_count_q;
	assign stat.min_count  = min_count_q;
	assign result          = result_q;

endmodule

// ===== src/mts_ctrl.sv =====
// ----------------------------------------------------------------------------
// mts_ctrl
// Sequencer: takes one item, lets a pop on a non-empty stack reload the tops
// from memory, then moves the result into the output register when it is free.
// ----------------------------------------------------------------------------
module mts_ctrl import mts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_func,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  mts_stat_t stat,
	output mts_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_LOAD   = 3'b010,
		S_RESULT = 3'b100
	} state_t;

	localparam logic FUNC_PUSH = 1'b0;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;

	// next state and commands
	always_comb begin
		state_d       = state_q;
		req_ready     = 1'b0;
		cmd.push_exec = 1'b0;
		cmd.pop_exec  = 1'b0;
		cmd.load_tops = 1'b0;
		cmd.load_out  = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_func == FUNC_PUSH) begin
						cmd.push_exec = 1'b1;
						state_d       = S_RESULT;
					end else begin
						cmd.pop_exec = 1'b1;
						state_d      = stat.empty ? S_RESULT : S_LOAD;
					end
				end
			end
			S_LOAD: begin
				cmd.load_tops = 1'b1;
				state_d       = S_RESULT;
			end
			S_RESULT: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule
